>>> sv/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)

`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/tcw_pkg.sv
package tcw_pkg;

  localparam int TASKS      = 4;
  localparam int TIME_BITS  = 32;
  localparam int TASK_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int ID_W       = 2;
  localparam int MODE_W     = 2;
  localparam int LATE_W     = 2;
  localparam int TIMEOUT_W  = 32;
  localparam int PERIOD_W   = 16;
  localparam int WD_W       = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WD_W-1:0]     PRELOAD_RST     = 12'hFBB;
  localparam logic [PERIOD_W-1:0] FEED_PERIOD_RST = 16'd300;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_CHECKIN = 2'd1,
    MODE_WDT     = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT0    = 3'd0,
    CFG_TIMEOUT1    = 3'd1,
    CFG_TIMEOUT2    = 3'd2,
    CFG_TIMEOUT3    = 3'd3,
    CFG_FEED_PERIOD = 3'd4,
    CFG_PRELOAD     = 3'd5,
    CFG_ENABLE      = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_RES
  } state_t;

  typedef struct packed {
    logic              fed;
    logic              missed;
    logic [LATE_W-1:0] late_task;
    logic              wd_reset;
  } res_t;

endpackage

>>> sv/tcw_in_if.sv
interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   task_id;

  modport source (output valid, output mode, output task_id, input ready);
  modport sink   (input valid, input mode, input task_id, output ready);
endinterface

>>> sv/tcw_out_if.sv
interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic              fed;
  logic              missed;
  logic [LATE_W-1:0] late_task;
  logic              wd_reset;

  modport source (output valid, output fed, output missed, output late_task,
                  output wd_reset, input ready);
  modport sink   (input valid, input fed, input missed, input late_task,
                  input wd_reset, output ready);
endinterface

>>> sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/task_checkin_watchdog_core.sv
// Task check-in watchdog supervisor. Each input transaction is a scheduler
// tick, a task check-in, a prescaled watchdog tick or an unused mode, and
// yields exactly one result transaction. Check-ins, watchdog ticks and
// scheduler ticks that do not end a feed period go from acceptance to the
// result state. A tick that ends a feed period scans the task check-in
// memory one entry at a time through its single read port, with a read and
// a compare state per task, stopping early at the first late task. A
// finished result waits in the output register while the next transaction
// is accepted. Configuration writes take effect on the next clock edge.
`include "assert_macros.svh"

module task_checkin_watchdog_core (
  input  logic                            clk,
  input  logic                            rst_n,
  tcw_in_if.sink                          in_chan,
  tcw_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_r [TASKS];
  logic [PERIOD_W-1:0]  feed_period_r;
  logic [WD_W-1:0]      preload_r;
  logic                 enable_r;

  state_t               state_r, state_nxt;
  logic [TASK_W-1:0]    idx_r, idx_nxt;
  logic [TIME_BITS-1:0] cur_time_r, cur_time_nxt;
  logic [PERIOD_W-1:0]  period_cnt_r, period_cnt_nxt;
  logic [WD_W-1:0]      wd_cnt_r, wd_cnt_nxt;
  logic                 reset_flag_r, reset_flag_nxt;
  logic [TASKS-1:0]     valid_r, valid_nxt;
  res_t                 res_r, res_nxt;
  res_t                 out_r;
  logic                 out_valid_r;

  logic                 acc;
  logic                 out_take;
  logic                 out_load;
  logic [PERIOD_W-1:0]  period_eff;
  logic [PERIOD_W-1:0]  period_inc;
  logic                 scan_start;
  logic                 task_ok;
  logic [TASK_W-1:0]    task_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] elapsed;
  logic                 late_hit;
  logic                 last_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        timeout_r[i] <= '0;
      end
      feed_period_r <= FEED_PERIOD_RST;
      preload_r     <= PRELOAD_RST;
      enable_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEED_PERIOD: feed_period_r <= cfg_data[PERIOD_W-1:0];
        CFG_PRELOAD:     preload_r     <= cfg_data[WD_W-1:0];
        CFG_ENABLE:      enable_r      <= cfg_data[0];
        default: begin
          if ({1'b0, cfg_index} < (CFG_IDX_W+1)'(TASKS)) begin
            timeout_r[cfg_index[TASK_W-1:0]] <= cfg_data[TIMEOUT_W-1:0];
          end
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (task_addr),
    .wdata (cur_time_r),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign acc        = in_chan.valid && in_chan.ready;
  assign out_take   = !out_valid_r || out_chan.ready;
  assign period_eff = (feed_period_r == '0) ? PERIOD_W'(1) : feed_period_r;
  assign period_inc = period_cnt_r + PERIOD_W'(1);
  assign scan_start = (in_chan.mode == MODE_TICK) && (period_inc >= period_eff);
  assign task_ok    = {1'b0, in_chan.task_id} < (ID_W+1)'(TASKS);
  assign task_addr  = in_chan.task_id[TASK_W-1:0];
  assign last_time  = valid_r[idx_r] ? ram_rdata : '0;
  assign elapsed    = cur_time_r - last_time;
  assign late_hit   = TIMEOUT_W'(elapsed) >= timeout_r[idx_r];
  assign last_idx   = idx_r == TASK_W'(TASKS - 1);

  // datapath next values
  always_comb begin
    cur_time_nxt   = cur_time_r;
    period_cnt_nxt = period_cnt_r;
    wd_cnt_nxt     = wd_cnt_r;
    reset_flag_nxt = reset_flag_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_nxt = '0;
          idx_nxt = '0;
          case (in_chan.mode)
            MODE_TICK: begin
              cur_time_nxt   = cur_time_r + TIME_BITS'(1);
              period_cnt_nxt = scan_start ? '0 : period_inc;
            end
            MODE_CHECKIN: begin
              if (task_ok) begin
                ram_we               = 1'b1;
                valid_nxt[task_addr] = 1'b1;
              end
            end
            MODE_WDT: begin
              if (enable_r) begin
                if (wd_cnt_r == '0) begin
                  reset_flag_nxt = 1'b1;
                  wd_cnt_nxt     = preload_r;
                end else begin
                  wd_cnt_nxt = wd_cnt_r - WD_W'(1);
                end
              end
            end
            default: ;
          endcase
          res_nxt.wd_reset = reset_flag_nxt;
        end
      end
      ST_CMP: begin
        if (late_hit) begin
          res_nxt.missed    = 1'b1;
          res_nxt.late_task = LATE_W'(idx_r);
        end else if (last_idx) begin
          res_nxt.fed = 1'b1;
          wd_cnt_nxt  = preload_r;
        end else begin
          idx_nxt = idx_r + TASK_W'(1);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = scan_start ? ST_RD : ST_RES;
        end
      end
      ST_RD:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (late_hit || last_idx) begin
          state_nxt = ST_RES;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RES: begin
        if (out_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_chan.ready = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_RD:   ram_re        = 1'b1;
      ST_RES:  out_load      = out_take;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      cur_time_r   <= '0;
      period_cnt_r <= '0;
      wd_cnt_r     <= PRELOAD_RST;
      reset_flag_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cur_time_r   <= cur_time_nxt;
      period_cnt_r <= period_cnt_nxt;
      wd_cnt_r     <= wd_cnt_nxt;
      reset_flag_r <= reset_flag_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.fed       = out_r.fed;
  assign out_chan.missed    = out_r.missed;
  assign out_chan.late_task = out_r.late_task;
  assign out_chan.wd_reset  = out_r.wd_reset;

  `TCW_ASSERT(a_fed_missed_excl, clk, rst_n, out_valid_r |-> !(out_r.fed && out_r.missed), "fed and missed both set")
  `TCW_ASSERT(a_flag_sticky, clk, rst_n, reset_flag_r |=> reset_flag_r, "watchdog reset flag cleared")
  `TCW_ASSERT(a_late_needs_miss, clk, rst_n, (out_valid_r && out_r.late_task != '0) |-> out_r.missed, "late task without miss")
  `TCW_ASSERT(a_no_scan_off_tick, clk, rst_n, (acc && in_chan.mode != MODE_TICK) |=> state_r == ST_RES, "scan started by non-tick transaction")
  `TCW_ASSERT(a_feed_reload, clk, rst_n, (state_r == ST_CMP && !late_hit && last_idx) |=> wd_cnt_r == $past(preload_r), "feed did not reload counter")

endmodule

>>> sim/task_checkin_watchdog_core_tb.sv
`timescale 1ns / 1ps

module task_checkin_watchdog_core_tb;
  import tcw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RX_HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  task_checkin_watchdog_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [TIMEOUT_W-1:0] task_timeout [TASKS] = '{default: '0};
  logic [PERIOD_W-1:0]  scan_period = FEED_PERIOD_RST;
  logic [WD_W-1:0]      wd_preload = PRELOAD_RST;
  logic                 wd_enable = 1'b0;

  logic [TIME_BITS-1:0] sched_time = '0;
  logic [TIME_BITS-1:0] last_checkin_at [TASKS] = '{default: '0};
  logic [PERIOD_W-1:0]  period_cnt = '0;
  logic [WD_W-1:0]      wd_cnt = PRELOAD_RST;
  logic                 wd_fired = 1'b0;

  res_t pending_verdicts [$];
  int   errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   rx_hold_left = 0;

  function automatic string res_text(res_t r);
    return $sformatf("fed=%0b missed=%0b late=%0d wd_reset=%0b",
                     r.fed, r.missed, r.late_task, r.wd_reset);
  endfunction

  function automatic res_t advance_supervisor(logic [MODE_W-1:0] m, logic [ID_W-1:0] id);
    res_t r;
    logic [PERIOD_W-1:0] period;
    bit late_found;
    r = '0;
    late_found = 1'b0;
    case (m)
      MODE_TICK: begin
        period = (scan_period == '0) ? PERIOD_W'(1) : scan_period;
        sched_time = sched_time + TIME_BITS'(1);
        period_cnt = period_cnt + PERIOD_W'(1);
        if (period_cnt >= period) begin
          period_cnt = '0;
          for (int t = 0; t < TASKS; t++) begin
            if (!late_found && (sched_time - last_checkin_at[t]) >= task_timeout[t]) begin
              late_found = 1'b1;
              r.late_task = LATE_W'(t);
            end
          end
          if (late_found) begin
            r.missed = 1'b1;
          end else begin
            r.fed = 1'b1;
            wd_cnt = wd_preload;
          end
        end
      end
      MODE_CHECKIN: begin
        if (int'(id) < TASKS) last_checkin_at[id] = sched_time;
      end
      MODE_WDT: begin
        if (wd_enable) begin
          if (wd_cnt == '0) begin
            wd_fired = 1'b1;
            wd_cnt = wd_preload;
          end else begin
            wd_cnt = wd_cnt - WD_W'(1);
          end
        end
      end
      default: ;
    endcase
    r.wd_reset = wd_fired;
    return r;
  endfunction

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.fed       = out_if.fed;
      got.missed    = out_if.missed;
      got.late_task = out_if.late_task;
      got.wd_reset  = out_if.wd_reset;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: expected none, actual %s",
                 $time, res_text(got));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.fed !== want.fed || got.missed !== want.missed ||
            got.late_task !== want.late_task || got.wd_reset !== want.wd_reset) begin
          errors++;
          $display("%0t: mismatch: expected %s, actual %s",
                   $time, res_text(want), res_text(got));
        end
      end
    end
  end

  task automatic offer_event(logic [MODE_W-1:0] m, logic [ID_W-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.task_id <= id;
    do @(posedge clk); while (!in_if.ready);
    pending_verdicts.push_back(advance_supervisor(m, id));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_TIMEOUT0, CFG_TIMEOUT1, CFG_TIMEOUT2, CFG_TIMEOUT3: task_timeout[idx[1:0]] = val;
      CFG_FEED_PERIOD: scan_period = val[PERIOD_W-1:0];
      CFG_PRELOAD:     wd_preload = val[WD_W-1:0];
      CFG_ENABLE:      wd_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic random_config(bit en, logic [WD_W-1:0] pl);
    logic [TIMEOUT_W-1:0] tmo;
    for (int t = 0; t < TASKS; t++) begin
      case ($urandom_range(9))
        0:       tmo = '0;
        1:       tmo = '1;
        2:       tmo = $urandom;
        default: tmo = $urandom_range(4, 48);
      endcase
      write_reg(cfg_idx_t'(int'(CFG_TIMEOUT0) + t), tmo);
    end
    write_reg(CFG_FEED_PERIOD, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10));
    write_reg(CFG_PRELOAD, CFG_DATA_W'(pl));
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
  endtask

  task automatic random_events(int count);
    int pick;
    logic [ID_W-1:0] id;
    repeat (count) begin
      pick = $urandom_range(99);
      id = ID_W'($urandom_range(TASKS - 1));
      if (pick < 52)      offer_event(MODE_TICK, id);
      else if (pick < 82) offer_event(MODE_CHECKIN, id);
      else if (pick < 95) offer_event(MODE_WDT, id);
      else                offer_event(MODE_UNUSED, id);
    end
  endtask

  task automatic test_after_reset();
    offer_event(MODE_UNUSED, 2'd3);
    for (int t = 0; t < TASKS; t++) offer_event(MODE_CHECKIN, ID_W'(t));
    offer_event(MODE_WDT, 2'd0);
    offer_event(MODE_TICK, 2'd0);
    wait_drained();
    write_reg(CFG_FEED_PERIOD, 0);
    offer_event(MODE_TICK, 2'd0);
  endtask

  task automatic test_scan_order();
    wait_drained();
    write_reg(CFG_TIMEOUT0, '1);
    write_reg(CFG_TIMEOUT1, '1);
    write_reg(CFG_TIMEOUT2, 3);
    write_reg(CFG_TIMEOUT3, '1);
    write_reg(CFG_FEED_PERIOD, 1);
    offer_event(MODE_CHECKIN, 2'd2);
    repeat (3) offer_event(MODE_TICK, 2'd0);
    offer_event(MODE_CHECKIN, 2'd2);
    offer_event(MODE_TICK, 2'd0);
    wait_drained();
    write_reg(CFG_TIMEOUT3, 0);
    offer_event(MODE_TICK, 2'd0);
    wait_drained();
    write_reg(CFG_TIMEOUT3, '1);
    write_reg(CFG_TIMEOUT1, 0);
    offer_event(MODE_TICK, 2'd0);
  endtask

  task automatic test_period_lowered();
    wait_drained();
    write_reg(CFG_FEED_PERIOD, 32'h0000_FFFF);
    repeat (4) offer_event(MODE_TICK, 2'd0);
    wait_drained();
    write_reg(CFG_FEED_PERIOD, 2);
    offer_event(MODE_TICK, 2'd0);
  endtask

  task automatic test_random_traffic(bit en, logic [WD_W-1:0] pl, int count);
    wait_drained();
    random_config(en, pl);
    random_events(count);
  endtask

  task automatic test_backpressure();
    wait_drained();
    random_config(1'b1, '1);
    rx_hold_left = RX_HOLD_CYCLES;
    random_events(60);
    wait_drained();
    random_events(20);
  endtask

  task automatic test_expiry();
    wait_drained();
    for (int t = 0; t < TASKS; t++) write_reg(cfg_idx_t'(int'(CFG_TIMEOUT0) + t), '1);
    write_reg(CFG_FEED_PERIOD, 1);
    write_reg(CFG_PRELOAD, 2);
    write_reg(CFG_ENABLE, 1);
    offer_event(MODE_TICK, 2'd0);
    repeat (3) offer_event(MODE_WDT, 2'd0);
    wait_drained();
    write_reg(CFG_ENABLE, 0);
    offer_event(MODE_WDT, 2'd0);
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_TICK;
    in_if.task_id = '0;
    out_if.ready  = 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 66;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_scan_order();
    test_period_lowered();
    test_random_traffic(1'b1, '1, 200);
    test_random_traffic(1'b0, WD_W'($urandom_range(0, 4095)), 200);
    test_random_traffic(1'b1, '1, 200);

    tx_idle_pct = 66;
    rx_idle_pct = 31;
    test_random_traffic(1'b0, '0, 200);
    test_random_traffic(1'b1, '1, 200);
    test_random_traffic(1'b0, WD_W'($urandom_range(0, 4095)), 200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_expiry();
    test_random_traffic(1'b1, WD_W'($urandom_range(0, 7)), 200);
    test_random_traffic(1'b1, '0, 200);
    test_random_traffic(1'b0, WD_W'($urandom_range(0, 4095)), 200);

    wait_drained();
    if (errors == 0) begin
      $display("task_checkin_watchdog_core_tb passed");
    end else begin
      $display("task_checkin_watchdog_core_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("task_checkin_watchdog_core_tb failed");
    $finish;
  end

endmodule

>>> task_checkin_watchdog_core.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_in_if.sv
sv/tcw_out_if.sv
sv/tcw_ram.sv
sv/task_checkin_watchdog_core.sv
sim/task_checkin_watchdog_core_tb.sv
